// ===== src/sgdm_pkg.sv =====
package sgdm_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned FracBits    = 24;
  localparam int unsigned CoeffWidth  = FracBits + 1;
  localparam int unsigned ProdWidth   = DataWidth + CoeffWidth;
  localparam int unsigned MagWidth    = ProdWidth - FracBits;
  localparam int unsigned NumStages   = 12;
  localparam int unsigned CfgIdxWidth = 3;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic [CoeffWidth-1:0]       coeff_t;

  localparam coeff_t OneQ    = {1'b1, {FracBits{1'b0}}};
  localparam data_t  DataMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam data_t  DataMin = {1'b1, {(DataWidth-1){1'b0}}};

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDecayEn    = 3'd0,
    CfgDecayCoeff = 3'd1,
    CfgMomEn      = 3'd2,
    CfgMomCoeff   = 3'd3,
    CfgDampCoeff  = 3'd4,
    CfgNestEn     = 3'd5,
    CfgLearnRate  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    data_t val;
    logic  sat;
  } sat_res_t;

  // one word in flight
  typedef struct packed {
    data_t grad;
    data_t weight;
    data_t buffer;
    logic  present;
    logic  sat;
  } stage_t;

  // pipeline valids (bit 0 is the input side) and per-stage load enables
  typedef struct packed {
    logic [NumStages:0]   vld;
    logic [NumStages+1:1] adv;
  } flow_t;

  function automatic sat_res_t sat_add(data_t a, data_t b);
    logic [DataWidth:0] sum;
    sat_res_t           res;
    sum     = {a[DataWidth-1], a} + {b[DataWidth-1], b};
    res.sat = sum[DataWidth] != sum[DataWidth-1];
    res.val = res.sat ? (sum[DataWidth] ? DataMin : DataMax) : data_t'(sum[DataWidth-1:0]);
    return res;
  endfunction

  function automatic sat_res_t sat_sub(data_t a, data_t b);
    logic [DataWidth:0] dif;
    sat_res_t           res;
    dif     = {a[DataWidth-1], a} - {b[DataWidth-1], b};
    res.sat = dif[DataWidth] != dif[DataWidth-1];
    res.val = res.sat ? (dif[DataWidth] ? DataMin : DataMax) : data_t'(dif[DataWidth-1:0]);
    return res;
  endfunction

  // 1 - dampening, clamped at zero
  function automatic coeff_t keep_factor(coeff_t damp);
    return (damp >= OneQ) ? '0 : coeff_t'(OneQ - damp);
  endfunction

endpackage

// ===== src/sgdm_mul.sv =====
module sgdm_mul (
  input  logic           clk_i,
  input  logic           en_a_i,
  input  logic           en_b_i,
  input  sgdm_pkg::data_t  x_i,
  input  sgdm_pkg::coeff_t c_i,
  output sgdm_pkg::data_t  y_o,
  output logic           sat_o
);
  import sgdm_pkg::*;

  localparam logic [ProdWidth-1:0] RoundHalf = ProdWidth'(1) << (FracBits - 1);
  localparam logic [MagWidth-1:0]  PosLim    = (MagWidth'(1) << (DataWidth - 1)) - 1'b1;
  localparam logic [MagWidth-1:0]  NegLim    = MagWidth'(1) << (DataWidth - 1);

  logic [DataWidth-1:0] mag;
  logic [ProdWidth-1:0] prod_d, prod_q;
  logic                 neg_q;
  logic [ProdWidth-1:0] rnd;
  logic [MagWidth-1:0]  mag_r, lim, mag_c;
  logic                 ovf;
  data_t                y_d, y_q;
  logic                 sat_q;

  // stage A: magnitude times coefficient
  assign mag    = x_i[DataWidth-1] ? (~unsigned'(x_i) + 1'b1) : unsigned'(x_i);
  assign prod_d = ProdWidth'(mag) * ProdWidth'(c_i);

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      prod_q <= prod_d;
      neg_q  <= x_i[DataWidth-1];
    end
  end

  // stage B: round half away from zero, clip, restore sign
  assign rnd   = prod_q + RoundHalf;
  assign mag_r = rnd[ProdWidth-1:FracBits];
  assign lim   = neg_q ? NegLim : PosLim;
  assign ovf   = mag_r > lim;
  assign mag_c = ovf ? lim : mag_r;
  assign y_d   = neg_q ? data_t'(-mag_c[DataWidth-1:0]) : data_t'(mag_c[DataWidth-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      y_q   <= y_d;
      sat_q <= ovf;
    end
  end

  assign y_o   = y_q;
  assign sat_o = sat_q;

endmodule

// ===== src/sgdm_flow.sv =====
module sgdm_flow (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  output sgdm_pkg::flow_t flow_o
);
  import sgdm_pkg::*;

  logic [NumStages:1]   vld_q;
  logic [NumStages+1:1] adv;

  // a stage loads when the output drains or any stage at or after it is empty
  always_comb begin
    adv[NumStages+1] = !out_stall_i;
    for (int unsigned k = 1; k <= NumStages; k++) begin
      adv[k] = !out_stall_i || ((~vld_q >> (k - 1)) != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int unsigned k = 2; k <= NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign flow_o.vld = {vld_q, in_valid_i};
  assign flow_o.adv = adv;

endmodule

// ===== src/sgd_momentum_update.sv =====
// SGD momentum update, one element per word.
// Throughput: one word per cycle unless the output stalls and no bubble is left;
// four chained two-stage multiplies plus four sums set the depth.
// Pipeline bubbles collapse under output stall, so input keeps flowing while holes remain.
// Reset (async, active low) clears all stage valids and all config registers to zero.
module sgd_momentum_update (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sgdm_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [sgdm_pkg::CoeffWidth-1:0]    cfg_data_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  sgdm_pkg::data_t                    grad_in_i,
  input  sgdm_pkg::data_t                    weight_in_i,
  input  sgdm_pkg::data_t                    buffer_in_i,
  input  logic                               buffer_present_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sgdm_pkg::data_t                    weight_out_o,
  output sgdm_pkg::data_t                    buffer_out_o,
  output logic                               buffer_out_present_o,
  output logic                               saturated_o
);
  import sgdm_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready; the block does not enforce it, but they must be written only while idle
  // ---------------------------------------------------------------------------
  logic   decay_en_q, mom_en_q, nest_en_q;
  coeff_t decay_q, mom_q, damp_q, lr_q;
  coeff_t keep;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_en_q <= 1'b0;
      decay_q    <= '0;
      mom_en_q   <= 1'b0;
      mom_q      <= '0;
      damp_q     <= '0;
      nest_en_q  <= 1'b0;
      lr_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgDecayEn:    decay_en_q <= cfg_data_i[0];
        CfgDecayCoeff: decay_q    <= cfg_data_i;
        CfgMomEn:      mom_en_q   <= cfg_data_i[0];
        CfgMomCoeff:   mom_q      <= cfg_data_i;
        CfgDampCoeff:  damp_q     <= cfg_data_i;
        CfgNestEn:     nest_en_q  <= cfg_data_i[0];
        CfgLearnRate:  lr_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign keep = keep_factor(damp_q);

  // ---------------------------------------------------------------------------
  // Flow control: valids per stage, stall collapses bubbles
  // ---------------------------------------------------------------------------
  flow_t flow;

  sgdm_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .flow_o      (flow)
  );

  assign in_stall_o = !flow.adv[1];

  // ---------------------------------------------------------------------------
  // Stage map
  //   1-2   decay product  weight * decay
  //   3     grad += decay product
  //   4-5   buffer * momentum, grad * (1 - dampening)
  //   6     new buffer (sum, or grad when no buffer yet)
  //   7-8   new buffer * momentum
  //   9     step direction (Nesterov sum or buffer)
  //   10-11 direction * learning rate
  //   12    weight -= step; output register
  // ---------------------------------------------------------------------------
  stage_t in_st;
  stage_t st_d [1:NumStages];
  stage_t st_q [1:NumStages];

  assign in_st = '{grad: grad_in_i, weight: weight_in_i, buffer: buffer_in_i,
                   present: buffer_present_i, sat: 1'b0};

  data_t dec_y, mb_y, mg_y, mn_y, lr_y;
  logic  dec_s, mb_s, mg_s, mn_s, lr_s;

  sgdm_mul u_mul_decay (
    .clk_i (clk_i), .en_a_i (flow.adv[1]), .en_b_i (flow.adv[2]),
    .x_i (weight_in_i), .c_i (decay_q), .y_o (dec_y), .sat_o (dec_s)
  );

  sgdm_mul u_mul_buf (
    .clk_i (clk_i), .en_a_i (flow.adv[4]), .en_b_i (flow.adv[5]),
    .x_i (st_q[3].buffer), .c_i (mom_q), .y_o (mb_y), .sat_o (mb_s)
  );

  sgdm_mul u_mul_grad (
    .clk_i (clk_i), .en_a_i (flow.adv[4]), .en_b_i (flow.adv[5]),
    .x_i (st_q[3].grad), .c_i (keep), .y_o (mg_y), .sat_o (mg_s)
  );

  sgdm_mul u_mul_nest (
    .clk_i (clk_i), .en_a_i (flow.adv[7]), .en_b_i (flow.adv[8]),
    .x_i (st_q[6].buffer), .c_i (mom_q), .y_o (mn_y), .sat_o (mn_s)
  );

  sgdm_mul u_mul_lr (
    .clk_i (clk_i), .en_a_i (flow.adv[10]), .en_b_i (flow.adv[11]),
    .x_i (st_q[9].grad), .c_i (lr_q), .y_o (lr_y), .sat_o (lr_s)
  );

  sat_res_t dec_sum, buf_sum, nest_sum, w_dif;

  assign dec_sum  = sat_add(st_q[2].grad, dec_y);
  assign buf_sum  = sat_add(mb_y, mg_y);
  assign nest_sum = sat_add(st_q[8].grad, mn_y);
  assign w_dif    = sat_sub(st_q[11].weight, lr_y);

  always_comb begin
    st_d[1] = in_st;
    for (int unsigned k = 2; k <= NumStages; k++) begin
      st_d[k] = st_q[k-1];
    end

    // weight decay: flags only count when the term is used
    if (decay_en_q) begin
      st_d[3].grad = dec_sum.val;
      st_d[3].sat  = st_q[2].sat | dec_s | dec_sum.sat;
    end

    // momentum buffer
    if (mom_en_q) begin
      if (st_q[5].present) begin
        st_d[6].buffer = buf_sum.val;
        st_d[6].sat    = st_q[5].sat | mb_s | mg_s | buf_sum.sat;
      end else begin
        st_d[6].buffer = st_q[5].grad;
      end
      st_d[6].present = 1'b1;
    end

    // step direction
    if (mom_en_q) begin
      if (nest_en_q) begin
        st_d[9].grad = nest_sum.val;
        st_d[9].sat  = st_q[8].sat | mn_s | nest_sum.sat;
      end else begin
        st_d[9].grad = st_q[8].buffer;
      end
    end

    // weight update
    st_d[12].weight = w_dif.val;
    st_d[12].sat    = st_q[11].sat | lr_s | w_dif.sat;
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned k = 1; k <= NumStages; k++) begin
      if (flow.adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_valid_o          = flow.vld[NumStages];
  assign weight_out_o         = st_q[NumStages].weight;
  assign buffer_out_o         = st_q[NumStages].buffer;
  assign buffer_out_present_o = st_q[NumStages].present;
  assign saturated_o          = st_q[NumStages].sat;

endmodule

// ===== src/sgdm_checker.sv =====
module sgdm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [sgdm_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input logic [sgdm_pkg::CoeffWidth-1:0]  cfg_data_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input sgdm_pkg::data_t                  weight_out_o,
  input sgdm_pkg::data_t                  buffer_out_o,
  input logic                             buffer_out_present_o
);
  import sgdm_pkg::*;

  // shadow of the momentum enable as seen on the config port
  logic mom_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mom_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o && cfg_index_i == CfgMomEn) begin
      mom_en_q <= cfg_data_i[0];
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped under stall");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(weight_out_o) && $stable(buffer_out_o))
    else $error("stalled result word changed");

  a_no_input_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_buffer_present : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mom_en_q |-> buffer_out_present_o)
    else $error("momentum on but buffer not marked present");

endmodule

bind sgd_momentum_update sgdm_checker u_sgdm_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .cfg_valid_i          (cfg_valid_i),
  .cfg_ready_o          (cfg_ready_o),
  .cfg_index_i          (cfg_index_i),
  .cfg_data_i           (cfg_data_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .weight_out_o         (weight_out_o),
  .buffer_out_o         (buffer_out_o),
  .buffer_out_present_o (buffer_out_present_o)
);

// ===== bench/sgd_momentum_update_tb.sv =====
`timescale 1ns / 100ps

module sgd_momentum_update_tb;
  import sgdm_pkg::*;

  // expected fields of one result word
  typedef struct {
    data_t weight;
    data_t buffer;
    logic  present;
    logic  sat;
  } update_t;

  // local copy of the optimizer registers
  typedef struct {
    bit     decay_en;
    coeff_t decay_k;
    bit     mom_en;
    coeff_t mom_k;
    coeff_t damp_k;
    bit     nest_en;
    coeff_t lr;
  } opt_cfg_t;

  localparam coeff_t CoeffMax = '1;   // largest 25-bit coefficient, about 2.0

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_valid_i;
  logic   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i;
  logic [CoeffWidth-1:0]  cfg_data_i;
  logic   in_valid_i;
  logic   in_stall_o;
  data_t  grad_in_i;
  data_t  weight_in_i;
  data_t  buffer_in_i;
  logic   buffer_present_i;
  logic   out_valid_o;
  logic   out_stall_i;
  data_t  weight_out_o;
  data_t  buffer_out_o;
  logic   buffer_out_present_o;
  logic   saturated_o;

  opt_cfg_t opt_cfg;
  update_t  pending_updates[$];
  int       mismatches;
  int       words_out;
  bit       gaps_on;    // random input gaps
  bit       stalls_on;  // random output stalls

  sgd_momentum_update u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .grad_in_i            (grad_in_i),
    .weight_in_i          (weight_in_i),
    .buffer_in_i          (buffer_in_i),
    .buffer_present_i     (buffer_present_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .weight_out_o         (weight_out_o),
    .buffer_out_o         (buffer_out_o),
    .buffer_out_present_o (buffer_out_present_o),
    .saturated_o          (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #16000000;
    $display("** sgd_momentum_update: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point arithmetic in 64-bit integers.
  // ---------------------------------------------------------------------------

  // sum clipped to the data range
  function automatic longint clip_sum(longint a, longint b, inout bit clip);
    longint r;
    r = a + b;
    if (r > longint'(DataMax)) begin
      clip = 1'b1;
      r    = longint'(DataMax);
    end else if (r < longint'(DataMin)) begin
      clip = 1'b1;
      r    = longint'(DataMin);
    end
    return r;
  endfunction

  // x * c / 2^FracBits, magnitude rounded half away from zero, then clipped
  function automatic longint scale_q(longint x, coeff_t c, inout bit clip);
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned lim;
    bit              neg;
    neg  = x < 0;
    mag  = neg ? longint'(-x) : x;
    prod = (mag * longint'(c) + (64'd1 << (FracBits - 1))) >> FracBits;
    lim  = longint'(DataMax) + (neg ? 1 : 0);
    if (prod > lim) begin
      clip = 1'b1;
      prod = lim;
    end
    return neg ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic update_t predict_update(data_t grad, data_t weight, data_t buffer,
                                             logic present);
    update_t res;
    bit      clip;
    longint  g, w, buf_v, t, u;
    coeff_t  keep;
    clip  = 1'b0;
    g     = grad;
    w     = weight;
    buf_v = buffer;
    res.present = present;
    if (opt_cfg.decay_en) begin
      t = scale_q(w, opt_cfg.decay_k, clip);
      g = clip_sum(g, t, clip);
    end
    if (opt_cfg.mom_en) begin
      if (!present) begin
        buf_v = g;  // first step: buffer starts as the decayed gradient
      end else begin
        keep  = (opt_cfg.damp_k >= OneQ) ? '0 : coeff_t'(OneQ - opt_cfg.damp_k);
        t     = scale_q(buf_v, opt_cfg.mom_k, clip);
        u     = scale_q(g, keep, clip);
        buf_v = clip_sum(t, u, clip);
      end
      res.present = 1'b1;
      if (opt_cfg.nest_en) begin
        t = scale_q(buf_v, opt_cfg.mom_k, clip);
        g = clip_sum(g, t, clip);
      end else begin
        g = buf_v;
      end
    end
    t = scale_q(g, opt_cfg.lr, clip);
    res.weight = data_t'(clip_sum(w, -t, clip));
    res.buffer = data_t'(buf_v);
    res.sat    = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes seen on the rising.
  // ---------------------------------------------------------------------------

  task automatic cfg_write(cfg_idx_e idx, coeff_t val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    case (idx)
      CfgDecayEn:    opt_cfg.decay_en = val[0];
      CfgDecayCoeff: opt_cfg.decay_k  = val;
      CfgMomEn:      opt_cfg.mom_en   = val[0];
      CfgMomCoeff:   opt_cfg.mom_k    = val;
      CfgDampCoeff:  opt_cfg.damp_k   = val;
      CfgNestEn:     opt_cfg.nest_en  = val[0];
      CfgLearnRate:  opt_cfg.lr       = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all(bit dec_en, coeff_t dec_k, bit mom_en, coeff_t mom_k,
                         coeff_t damp_k, bit nest_en, coeff_t lr);
    cfg_write(CfgDecayEn, coeff_t'(dec_en));
    cfg_write(CfgDecayCoeff, dec_k);
    cfg_write(CfgMomEn, coeff_t'(mom_en));
    cfg_write(CfgMomCoeff, mom_k);
    cfg_write(CfgDampCoeff, damp_k);
    cfg_write(CfgNestEn, coeff_t'(nest_en));
    cfg_write(CfgLearnRate, lr);
  endtask

  // valid stays high from word to word; only a gap lowers it
  task automatic send_word(data_t grad, data_t weight, data_t buffer, logic present);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    grad_in_i        <= grad;
    weight_in_i      <= weight;
    buffer_in_i      <= buffer;
    buffer_present_i <= present;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_updates.push_back(predict_update(grad, weight, buffer, present));
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // block idle: nothing in flight, registers may be rewritten
  task automatic drain();
    pause_input(1);
    wait (pending_updates.size() == 0);
    repeat (NumStages + 4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("%0t: word %0d %s got %0h expected %0h", $realtime, words_out, field, got,
             want);
  endtask

  always @(posedge clk_i) begin
    update_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected word", weight_out_o, 0);
      end else begin
        want = pending_updates.pop_front();
        if (weight_out_o !== want.weight)
          report_mismatch("weight_out", weight_out_o, want.weight);
        if (buffer_out_o !== want.buffer)
          report_mismatch("buffer_out", buffer_out_o, want.buffer);
        if (buffer_out_present_o !== want.present)
          report_mismatch("buffer_out_present", buffer_out_present_o, want.present);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", saturated_o, want.sat);
      end
      words_out++;
    end
  end

  // output backpressure in random bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stalls_on && rst_ni && $urandom_range(0, 11) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic data_t rand_data();
    case ($urandom_range(0, 9))
      0:       return DataMax;
      1:       return DataMin;
      2:       return '0;
      3, 4:    return data_t'(int'($urandom_range(0, 1 << 26)) - (1 << 25));  // between -2.0 and 2.0
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic coeff_t rand_coeff();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return OneQ;
      2:       return coeff_t'($urandom);   // may exceed one
      default: return coeff_t'($urandom_range(0, OneQ));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values: zero step, buffer passed through; then a full learning rate
  task automatic test_plain_step();
    send_word(32'sh0100_0000, 32'sh0200_0000, 32'sh1234_5678, 1'b1);
    drain();
    cfg_write(CfgLearnRate, OneQ);
    send_word(DataMax, DataMin, DataMin, 1'b0);   // difference clips low
    send_word(DataMin, DataMax, DataMax, 1'b1);   // difference clips high
    send_word('0, '0, '0, 1'b0);
    send_word(-32'sd1, 32'sd1, -32'sd1, 1'b1);
    drain();
  endtask

  task automatic test_weight_decay();
    cfg_write(CfgDecayEn, coeff_t'(1));
    cfg_write(CfgDecayCoeff, OneQ >> 1);
    cfg_write(CfgLearnRate, OneQ >> 2);
    send_word(DataMax, DataMax, '0, 1'b0);        // decayed gradient clips
    send_word('0, -32'sd3, '0, 1'b0);             // -1.5 ulp rounds away from zero
    send_word(DataMin, DataMin, '0, 1'b1);
    drain();
  endtask

  // momentum, missing buffer and dampening at and above one
  task automatic test_momentum();
    cfg_write(CfgDecayEn, '0);
    cfg_write(CfgMomEn, coeff_t'(1));
    cfg_write(CfgMomCoeff, 25'h0E6_6666);         // about 0.9
    cfg_write(CfgDampCoeff, '0);
    send_word(32'sh0300_0000, 32'sh0100_0000, 32'sh7777_7777, 1'b0);
    send_word(32'sh0300_0000, 32'sh0100_0000, 32'sh0200_0000, 1'b1);
    send_word(DataMin, DataMax, DataMin, 1'b1);
    drain();
    cfg_write(CfgDampCoeff, OneQ);
    send_word(32'sh0300_0000, 32'sh0100_0000, 32'sh0200_0000, 1'b1);
    drain();
    cfg_write(CfgDampCoeff, OneQ + 5);            // clamped factor, no saturation
    send_word(DataMax, 32'sh0100_0000, -32'sh0200_0000, 1'b1);
    drain();
  endtask

  task automatic test_nesterov();
    cfg_write(CfgNestEn, coeff_t'(1));
    cfg_write(CfgDampCoeff, OneQ >> 3);
    send_word(32'sh0080_0000, -32'sh0100_0000, 32'sh0040_0000, 1'b1);
    send_word(32'sh0080_0000, -32'sh0100_0000, 32'sh0040_0000, 1'b0);
    send_word(DataMax, DataMin, DataMax, 1'b1);
    drain();
  endtask

  // largest coefficients: every product but grad * (1 - dampening) can clip
  task automatic test_oversized_coeffs();
    set_all(1'b1, CoeffMax, 1'b1, CoeffMax, '0, 1'b1, CoeffMax);
    send_word(32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000, 1'b1);
    send_word(-32'sh0000_0001, 32'sh0000_0001, DataMin, 1'b1);
    send_word(32'sh0000_1000, -32'sh0000_1000, 32'sh0000_0800, 1'b0);
    drain();
  endtask

  // random words under a series of register settings
  task automatic test_random();
    int phase;
    int n;
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 0)
        set_all(1'b1, OneQ, 1'b1, OneQ, OneQ, 1'b1, OneQ);
      else if (phase == 1)
        set_all(1'b1, '0, 1'b1, '0, '0, 1'b0, '0);
      else
        set_all(bit'($urandom_range(0, 1)), rand_coeff(), bit'($urandom_range(0, 1)),
                rand_coeff(), rand_coeff(), bit'($urandom_range(0, 1)), rand_coeff());
      // last part of the run at full rate
      if (phase >= 10) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      for (n = 0; n < 150; n++) begin
        if (gaps_on && $urandom_range(0, 9) == 0)
          pause_input($urandom_range(1, 19));
        send_word(rand_data(), rand_data(), rand_data(), logic'($urandom_range(0, 1)));
      end
      drain();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CfgDecayEn;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    grad_in_i        = '0;
    weight_in_i      = '0;
    buffer_in_i      = '0;
    buffer_present_i = 1'b0;
    opt_cfg          = '{default: '0};
    mismatches       = 0;
    words_out        = 0;
    gaps_on          = 1'b1;
    stalls_on        = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_plain_step();
    test_weight_decay();
    test_momentum();
    test_nesterov();
    test_oversized_coeffs();
    test_random();

    if (mismatches == 0)
      $display("** sgd_momentum_update: PASSED **");
    else
      $display("** sgd_momentum_update: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sgdm_pkg.sv
src/sgdm_mul.sv
src/sgdm_flow.sv
src/sgd_momentum_update.sv
src/sgdm_checker.sv
bench/sgd_momentum_update_tb.sv
